// ===== hw/rtl/sha1_pkg.sv =====
// Shared types, constants and codes for the SHA-1 hash engine.
`timescale 1ns / 1ps

package sha1_pkg;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef logic [4:0][31:0] chain_t;

  localparam chain_t INIT_CHAIN = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5a827999;
  localparam logic [31:0] K_1 = 32'h6ed9eba1;
  localparam logic [31:0] K_2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_3 = 32'hca62c1d6;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_F1   = 7'd20;
  localparam logic [6:0] ROUND_F2   = 7'd40;
  localparam logic [6:0] ROUND_F3   = 7'd60;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [3:0] LEN_BYTES = 4'd8;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [31:0] msg_bytes;
  } qentry_t;

  typedef struct packed {
    logic        load;
    logic [31:0] word;
    logic        start;
    logic        reinit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

endpackage

// ===== hw/rtl/sha1_queue.sv =====
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module sha1_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sha1_pkg::qentry_t push_data,
  output logic             full,
  input  logic             pop,
  output sha1_pkg::qentry_t head,
  output logic             head_valid
);
  import sha1_pkg::*;

  localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  qentry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha1_front.sv =====
// Input side: accepts items, counts message bytes and queues classified entries.
`timescale 1ns / 1ps

module sha1_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [7:0]        data_byte,
  output logic              q_push,
  output sha1_pkg::qentry_t q_data,
  input  logic              q_full
);
  import sha1_pkg::*;

  logic [31:0] msg_bytes;
  op_t         op;

  assign op       = op_t'(operation);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.op        = op;
    q_data.data      = data_byte;
    q_data.msg_bytes = msg_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bytes <= '0;
    end else if (q_push) begin
      if (op == OP_FINISH) begin
        msg_bytes <= '0;
      end else begin
        msg_bytes <= msg_bytes + 32'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/sha1_compress.sv =====
// SHA-1 compression unit: one round per cycle over a sixteen-word schedule line.
`timescale 1ns / 1ps

module sha1_compress (
  input  logic             clk,
  input  logic             rst,
  input  sha1_pkg::cmd_t   cmd,
  output sha1_pkg::stat_t  stat,
  output sha1_pkg::chain_t chain
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FINAL = 3'b100
  } cstate_t;

  cstate_t           state;
  logic [6:0]        t;
  logic [31:0]       a, b, c, d, e;
  logic [15:0][31:0] sched;
  logic [31:0]       f, k, w_mix, w_new, nxt;

  always_comb begin
    priority if (t < ROUND_F1) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (t < ROUND_F2) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (t < ROUND_F3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
    w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    w_new = {w_mix[30:0], w_mix[31]};
    nxt   = {a[26:0], a[31:27]} + f + e + sched[0] + k;
  end

  assign stat.done = (state == C_FINAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      t     <= '0;
      chain <= INIT_CHAIN;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.reinit) begin
            chain <= INIT_CHAIN;
          end
          if (cmd.start) begin
            t     <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          t <= t + 7'd1;
          if (t == ROUND_LAST) begin
            state <= C_FINAL;
          end
        end
        C_FINAL: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          state    <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sched <= {cmd.word, sched[15:1]};
    end else if (state == C_ROUND) begin
      sched <= {w_new, sched[15:1]};
    end
    if (state == C_IDLE && cmd.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == C_ROUND) begin
      a <= nxt;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

endmodule

// ===== hw/rtl/sha1_back.sv =====
// Back part: packs bytes into words, generates padding and holds the digest.
`timescale 1ns / 1ps

module sha1_back (
  input  logic              clk,
  input  logic              rst,
  input  sha1_pkg::qentry_t head,
  input  logic              head_valid,
  output logic              pop,
  output sha1_pkg::cmd_t    cmd,
  input  sha1_pkg::stat_t   stat,
  input  sha1_pkg::chain_t  chain,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       digest_h0,
  output logic [31:0]       digest_h1,
  output logic [31:0]       digest_h2,
  output logic [31:0]       digest_h3,
  output logic [31:0]       digest_h4
);
  import sha1_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_PAD  = 4'b0010,
    B_WAIT = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_t;

  bstate_t     state;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [63:0] len_shift;
  logic        sent_80;
  logic [3:0]  len_idx;
  logic        pad_active;

  logic        push_en;
  logic [7:0]  push_byte;
  logic        pad_zero;
  logic        pad_len_byte;
  logic        block_full;
  logic        out_fire;

  assign pad_zero     = sent_80 && (len_idx == '0) && (fill != FILL_LEN);
  assign pad_len_byte = sent_80 && !pad_zero;
  assign block_full   = push_en && (fill == FILL_LAST);
  assign out_fire     = out_valid && !out_stall;

  always_comb begin
    push_en   = 1'b0;
    push_byte = head.data;
    pop       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          pop     = 1'b1;
          push_en = (head.op == OP_ABSORB);
        end
      end
      B_PAD: begin
        push_en = 1'b1;
        priority if (!sent_80) begin
          push_byte = PAD_BYTE;
        end else if (pad_zero) begin
          push_byte = 8'h00;
        end else begin
          push_byte = len_shift[63:56];
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.load   = push_en && (fill[1:0] == 2'b11);
    cmd.word   = {acc, push_byte};
    cmd.start  = block_full;
    cmd.reinit = (state == B_EMIT) && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      fill       <= '0;
      sent_80    <= 1'b0;
      len_idx    <= '0;
      pad_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (head_valid) begin
            if (head.op == OP_FINISH) begin
              sent_80    <= 1'b0;
              len_idx    <= '0;
              pad_active <= 1'b1;
              state      <= B_PAD;
            end else if (block_full) begin
              state <= B_WAIT;
            end
          end
        end
        B_PAD: begin
          if (!sent_80) begin
            sent_80 <= 1'b1;
          end else if (pad_len_byte) begin
            len_idx <= len_idx + 4'd1;
          end
          if (block_full) begin
            state <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (stat.done) begin
            priority if (len_idx == LEN_BYTES) begin
              state <= B_EMIT;
            end else if (pad_active) begin
              state <= B_PAD;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        B_EMIT: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            pad_active <= 1'b0;
            len_idx    <= '0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
    end
    if (state == B_IDLE && head_valid && head.op == OP_FINISH) begin
      len_shift <= {29'd0, head.msg_bytes, 3'd0};
    end else if (state == B_PAD && pad_len_byte) begin
      len_shift <= {len_shift[55:0], 8'h00};
    end
    if (state == B_EMIT && !out_valid) begin
      digest_h0 <= chain[0];
      digest_h1 <= chain[1];
      digest_h2 <= chain[2];
      digest_h3 <= chain[3];
      digest_h4 <= chain[4];
    end
  end

endmodule

// ===== hw/rtl/sha1_hash_engine.sv =====
// Top level of the byte-serial SHA-1 hash engine.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_stall   operation, data_byte
//   output   out        out_valid / out_stall digest_h0 .. digest_h4
//
// An absorbed byte is packed into the current word by the back part; each full
// 64-byte block is compressed in 80 rounds and one chaining add.
// A finish item leaves the queue, then 9 to 72 padding bytes, one or two
// compressions and the digest register load follow. Reset is synchronous
// and needs no sweep.
// The four-entry queue takes input transfers while a block compresses, until full;
// a waiting digest holds the back part only when the next digest is ready.
`timescale 1ns / 1ps

module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_h0,
  output logic [31:0] digest_h1,
  output logic [31:0] digest_h2,
  output logic [31:0] digest_h3,
  output logic [31:0] digest_h4
);
  import sha1_pkg::*;

  logic    q_push;
  qentry_t q_data;
  logic    q_full;
  logic    q_pop;
  qentry_t q_head;
  logic    q_head_valid;
  cmd_t    cmd;
  stat_t   stat;
  chain_t  chain;

  sha1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .data_byte (data_byte),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  sha1_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  sha1_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stat  (stat),
    .chain (chain)
  );

  sha1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .cmd        (cmd),
    .stat       (stat),
    .chain      (chain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_h0  (digest_h0),
    .digest_h1  (digest_h1),
    .digest_h2  (digest_h2),
    .digest_h3  (digest_h3),
    .digest_h4  (digest_h4)
  );

endmodule

// ===== test/sha1_digest_checker.sv =====
// Checker that predicts SHA-1 digests from input transfers and compares each output transfer.
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_h0,
  input  logic [31:0] digest_h1,
  input  logic [31:0] digest_h2,
  input  logic [31:0] digest_h3,
  input  logic [31:0] digest_h4,
  output int          fail_count,
  output int          pending_digests,
  output int          checked_digests
);
  import sha1_pkg::*;

  localparam chain_t START_CHAIN = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };
  localparam logic [3:0][31:0] ROUND_K = {
    32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
  };
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam int         BLOCK_LEN = 64;
  localparam int         LEN_SLOT  = 56;

  chain_t      hash_words = START_CHAIN;
  logic [7:0]  block_bytes [BLOCK_LEN];
  int unsigned block_fill = 0;
  logic [31:0] byte_total = '0;
  chain_t      predicted_digests [$];
  int          errors = 0;
  int          digests_seen = 0;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, nxt;
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 80; t++)
      w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    for (int t = 0; t < 80; t++) begin
      if (t < 20)
        f = (b & c) | (~b & d);
      else if (t >= 40 && t < 60)
        f = (b & c) | (b & d) | (c & d);
      else
        f = b ^ c ^ d;
      nxt = rotl(a, 5) + f + e + w[t] + ROUND_K[t / 20];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = nxt;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  function void absorb_byte(input logic [7:0] value);
    block_bytes[block_fill] = value;
    block_fill++;
    if (block_fill == BLOCK_LEN) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function chain_t finish_message();
    logic [63:0] bit_length;
    chain_t      digest;
    bit_length = {29'd0, byte_total, 3'd0};
    absorb_byte(PAD_MARK);
    while (block_fill != LEN_SLOT)
      absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--)
      absorb_byte(bit_length[8*i +: 8]);
    digest = hash_words;
    hash_words = START_CHAIN;
    block_fill = 0;
    byte_total = '0;
    return digest;
  endfunction

  always @(posedge clk) begin
    chain_t expected, actual;
    if (rst) begin
      hash_words = START_CHAIN;
      block_fill = 0;
      byte_total = '0;
      predicted_digests.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (op_t'(operation) == OP_FINISH) begin
          predicted_digests.push_back(finish_message());
        end else begin
          absorb_byte(data_byte);
          byte_total++;
        end
      end
      if (out_valid && !out_stall) begin
        actual = {digest_h4, digest_h3, digest_h2, digest_h1, digest_h0};
        if (predicted_digests.size() == 0) begin
          $error("Digest transfer with no finished message waiting: digest_h0 %08h", digest_h0);
          errors++;
        end else begin
          expected = predicted_digests.pop_front();
          digests_seen++;
          for (int i = 0; i < 5; i++) begin
            if (actual[i] !== expected[i]) begin
              $error("digest_h%0d mismatch: expected %08h, actual %08h",
                     i, expected[i], actual[i]);
              errors++;
            end
          end
        end
      end
    end
    fail_count      <= errors;
    pending_digests <= predicted_digests.size();
    checked_digests <= digests_seen;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the SHA-1 hash engine testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import sha1_pkg::*;

  localparam int ITEM_TARGET  = 1650;
  localparam int MIN_MESSAGES = 40;
  localparam int HOLD_CYCLES  = 1500;
  localparam int STALL_LIMIT  = 6000;
  localparam int TAIL_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_h0, digest_h1, digest_h2, digest_h3, digest_h4;

  int fail_count;
  int pending_digests;
  int checked_digests;

  logic hold_req = 1'b0;
  logic quiet_tail = 1'b0;
  bit   no_gaps = 1'b0;
  int   items_sent = 0;
  int   messages_sent = 0;
  int   longest_message = 0;
  int   pad_lengths [13] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

  always #2 clk = ~clk;

  sha1_hash_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest_h0 (digest_h0),
    .digest_h1 (digest_h1),
    .digest_h2 (digest_h2),
    .digest_h3 (digest_h3),
    .digest_h4 (digest_h4)
  );

  sha1_digest_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digest_h0       (digest_h0),
    .digest_h1       (digest_h1),
    .digest_h2       (digest_h2),
    .digest_h3       (digest_h3),
    .digest_h4       (digest_h4),
    .fail_count      (fail_count),
    .pending_digests (pending_digests),
    .checked_digests (checked_digests)
  );

  task automatic idle_sender();
    if (!no_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_item(input op_t op, input logic [7:0] value);
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int msg_len);
    for (int i = 0; i < msg_len; i++) begin
      idle_sender();
      send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    idle_sender();
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    messages_sent++;
    if (msg_len > longest_message)
      longest_message = msg_len;
  endtask

  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    bit pressure_done;
    int msg_len;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty messages, back to back, with the ignored byte at both extremes, then short messages.
    send_item(OP_FINISH, 8'hff);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h5a);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_FINISH, 8'ha5);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_FINISH, 8'h01);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_FINISH, 8'h80);
    messages_sent = 6;

    while (items_sent < ITEM_TARGET || messages_sent < MIN_MESSAGES) begin
      if (!pressure_done && items_sent >= ITEM_TARGET / 3) begin
        // The receiver holds off while short messages pile up digests.
        pressure_done = 1'b1;
        hold_req <= 1'b1;
        no_gaps = 1'b1;
        repeat (24) send_message($urandom_range(0, 3));
        no_gaps = 1'b0;
      end
      if (items_sent >= ITEM_TARGET * 9 / 10)
        quiet_tail <= 1'b1;
      if ($urandom_range(0, 1) == 1)
        msg_len = pad_lengths[$urandom_range(0, 12)];
      else
        msg_len = $urandom_range(0, 60);
      send_message(msg_len);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digests != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers in %0d messages of 0 to %0d bytes, %0d digests checked.",
             items_sent, messages_sent, longest_message, checked_digests);
    $display("Included a %0d-cycle receiver hold that backed up the input channel.",
             HOLD_CYCLES);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
